// ----- src/assert_macros.svh -----
// Assertion helpers shared by the sampler RTL.
// Each macro builds one labeled concurrent assertion on the rising clock edge.
// The check is switched off while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge out of reset.
`define CBS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a clock edge out of reset.
`define CBS_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ----- src/cbs_pkg.sv -----
// ----------------------------------------------------------------------------
// cbs_pkg
// Types, constants and helpers shared by the cubic Bezier sampler modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbs_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int SEG_W        = 7;
    localparam int T_W          = 17;
    localparam int COORD_W      = 32;
    localparam int DIV_CNT_W    = $clog2(T_W + 1);

    localparam logic [SEG_W-1:0] SEG_MIN   = 7'd1;
    localparam logic [SEG_W-1:0] SEG_MAX   = SEG_W'(MAX_SEGMENTS);
    localparam logic [SEG_W-1:0] SEG_RESET = 7'd16;

    // 1.0 in unsigned Q1.16.
    localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

    // Step size for the reset segment count: 65536 / 16.
    localparam logic [T_W-1:0]   RESET_QUOT = 17'd4096;
    localparam logic [SEG_W-1:0] RESET_REM  = 7'd0;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] ctrl_a_x;
        logic signed [COORD_W-1:0] ctrl_a_y;
        logic signed [COORD_W-1:0] ctrl_b_x;
        logic signed [COORD_W-1:0] ctrl_b_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } curve_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      last_point;
    } point_t;

    // One curve parameter value on its way into the evaluator.
    typedef struct packed {
        logic           valid;
        logic           last;
        logic [T_W-1:0] t;
    } sample_t;

    // Status of the serial divider that forms 65536 / segments.
    typedef struct packed {
        logic             busy;
        logic [T_W-1:0]   quotient;
        logic [SEG_W-1:0] remainder;
    } div_stat_t;

    function automatic logic [SEG_W-1:0] clamp_segments(input logic [SEG_W-1:0] v);
        logic [SEG_W-1:0] r;
        r = v;
        if (v == '0)
            r = SEG_MIN;
        else if (v > SEG_MAX)
            r = SEG_MAX;
        return r;
    endfunction

endpackage

// ----- src/cbs_divider.sv -----
// ----------------------------------------------------------------------------
// cbs_divider
// Restoring divider, one quotient bit per cycle, that forms 65536 / segments.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbs_divider
    import cbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SEG_W-1:0] divisor,
    output div_stat_t        stat
);

    logic [SEG_W-1:0]     rem_reg;
    logic [T_W-1:0]       quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SEG_W-1:0]     div_reg;

    logic [SEG_W:0]   trial;
    logic [SEG_W:0]   diff;
    logic             ge;
    logic [SEG_W-1:0] rem_next;

    // The quotient register starts out holding the dividend and shifts the
    // quotient bits in from the bottom as the dividend bits leave the top.
    assign trial    = {rem_reg, quo_reg[T_W-1]};
    assign ge       = trial >= {1'b0, div_reg};
    assign diff     = trial - {1'b0, div_reg};
    assign rem_next = ge ? diff[SEG_W-1:0] : trial[SEG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= RESET_REM;
            quo_reg <= RESET_QUOT;
            cnt_reg <= '0;
            div_reg <= SEG_RESET;
        end
        else if (start)
        begin
            rem_reg <= '0;
            quo_reg <= ONE_Q16;
            cnt_reg <= DIV_CNT_W'(T_W);
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[T_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign stat.busy      = cnt_reg != '0;
    assign stat.quotient  = quo_reg;
    assign stat.remainder = rem_reg;

endmodule

// ----- src/cbs_eval_pipe.sv -----
// ----------------------------------------------------------------------------
// cbs_eval_pipe
// Five-stage pipeline from a curve parameter t to one Bernstein-weighted point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbs_eval_pipe
    import cbs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  sample_t smp,
    input  curve_t  curve,
    output logic    point_valid,
    output point_t  point,
    output logic    pipe_busy
);

    localparam int PROD_W = 2 * T_W;
    localparam int MUL_W  = T_W + 1 + COORD_W;
    localparam int PAIR_W = MUL_W + 1;
    localparam int SUM_W  = MUL_W + 2;

    // Stage 1: u = 1 - t, squares of u and t.
    logic           s1_valid_reg;
    logic           s1_last_reg;
    logic [T_W-1:0] s1_t_reg;
    logic [T_W-1:0] s1_u_reg;
    logic [T_W-1:0] s1_t2_reg;
    logic [T_W-1:0] s1_u2_reg;

    logic [T_W-1:0]    u_next;
    logic [PROD_W-1:0] uu_prod;
    logic [PROD_W-1:0] tt_prod;

    assign u_next  = ONE_Q16 - smp.t;
    assign uu_prod = PROD_W'(u_next) * PROD_W'(u_next);
    assign tt_prod = PROD_W'(smp.t) * PROD_W'(smp.t);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= smp.valid;
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg <= smp.last;
        s1_t_reg    <= smp.t;
        s1_u_reg    <= u_next;
        s1_u2_reg   <= uu_prod[T_W+15:16];
        s1_t2_reg   <= tt_prod[T_W+15:16];
    end

    // Stage 2: the four Bernstein weights.
    logic           s2_valid_reg;
    logic           s2_last_reg;
    logic           s2_in_range_reg;
    logic [T_W-1:0] s2_w_reg [4];

    logic [PROD_W-1:0] u3_prod;
    logic [PROD_W-1:0] u2t_prod;
    logic [PROD_W-1:0] ut2_prod;
    logic [PROD_W-1:0] t3_prod;
    logic [T_W:0]      w1_triple;
    logic [T_W:0]      w2_triple;

    assign u3_prod   = PROD_W'(s1_u2_reg) * PROD_W'(s1_u_reg);
    assign u2t_prod  = PROD_W'(s1_u2_reg) * PROD_W'(s1_t_reg);
    assign ut2_prod  = PROD_W'(s1_u_reg) * PROD_W'(s1_t2_reg);
    assign t3_prod   = PROD_W'(s1_t2_reg) * PROD_W'(s1_t_reg);
    assign w1_triple = {u2t_prod[T_W+15:16], 1'b0} + {1'b0, u2t_prod[T_W+15:16]};
    assign w2_triple = {ut2_prod[T_W+15:16], 1'b0} + {1'b0, ut2_prod[T_W+15:16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_last_reg     <= s1_last_reg;
        s2_in_range_reg <= s1_t_reg <= ONE_Q16;
        s2_w_reg[0]     <= u3_prod[T_W+15:16];
        s2_w_reg[1]     <= w1_triple[T_W-1:0];
        s2_w_reg[2]     <= w2_triple[T_W-1:0];
        s2_w_reg[3]     <= t3_prod[T_W+15:16];
    end

    // Stage 3: weight times control point, per coordinate.
    logic                    s3_valid_reg;
    logic                    s3_last_reg;
    logic signed [MUL_W-1:0] s3_px_reg [4];
    logic signed [MUL_W-1:0] s3_py_reg [4];

    logic signed [COORD_W-1:0] px [4];
    logic signed [COORD_W-1:0] py [4];

    assign px[0] = curve.start_x;
    assign px[1] = curve.ctrl_a_x;
    assign px[2] = curve.ctrl_b_x;
    assign px[3] = curve.end_x;
    assign py[0] = curve.start_y;
    assign py[1] = curve.ctrl_a_y;
    assign py[2] = curve.ctrl_b_y;
    assign py[3] = curve.end_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s3_last_reg <= s2_last_reg;
        for (int k = 0; k < 4; k++)
        begin
            s3_px_reg[k] <= $signed({1'b0, s2_w_reg[k]}) * px[k];
            s3_py_reg[k] <= $signed({1'b0, s2_w_reg[k]}) * py[k];
        end
    end

    // Stage 4: pairwise sums.
    logic                     s4_valid_reg;
    logic                     s4_last_reg;
    logic signed [PAIR_W-1:0] s4_x01_reg;
    logic signed [PAIR_W-1:0] s4_x23_reg;
    logic signed [PAIR_W-1:0] s4_y01_reg;
    logic signed [PAIR_W-1:0] s4_y23_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_last_reg <= s3_last_reg;
        s4_x01_reg  <= PAIR_W'(s3_px_reg[0]) + PAIR_W'(s3_px_reg[1]);
        s4_x23_reg  <= PAIR_W'(s3_px_reg[2]) + PAIR_W'(s3_px_reg[3]);
        s4_y01_reg  <= PAIR_W'(s3_py_reg[0]) + PAIR_W'(s3_py_reg[1]);
        s4_y23_reg  <= PAIR_W'(s3_py_reg[2]) + PAIR_W'(s3_py_reg[3]);
    end

    // Stage 5: final sum; dropping the low 16 bits of the two's complement
    // sum is the floor of the Q16 result.
    logic                    point_valid_reg;
    point_t                  point_reg;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    assign sum_x = SUM_W'(s4_x01_reg) + SUM_W'(s4_x23_reg);
    assign sum_y = SUM_W'(s4_y01_reg) + SUM_W'(s4_y23_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_valid_reg <= 1'b0;
        else
            point_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        point_reg.point_x    <= sum_x[COORD_W+15:16];
        point_reg.point_y    <= sum_y[COORD_W+15:16];
        point_reg.last_point <= s4_last_reg;
    end

    assign point_valid = point_valid_reg;
    assign point       = point_reg;
    assign pipe_busy   = s1_valid_reg | s2_valid_reg | s3_valid_reg | s4_valid_reg
                       | point_valid_reg;

    logic [T_W:0] ut_sum;
    logic [T_W+1:0] w_sum;

    assign ut_sum = {1'b0, s1_u_reg} + {1'b0, s1_t_reg};
    assign w_sum  = {2'b0, s2_w_reg[0]} + {2'b0, s2_w_reg[1]}
                  + {2'b0, s2_w_reg[2]} + {2'b0, s2_w_reg[3]};

    `CBS_ASSERT(a_u_plus_t_is_one, clk, rst_n,
        s1_valid_reg && (s1_t_reg <= ONE_Q16) |-> ut_sum == {1'b0, ONE_Q16},
        "u and t do not add up to one")
    `CBS_ASSERT(a_weights_bounded, clk, rst_n,
        s2_valid_reg && s2_in_range_reg |-> w_sum <= {2'b0, ONE_Q16},
        "Bernstein weights add up to more than one")
    `CBS_ASSERT(a_gap_after_last, clk, rst_n,
        point_valid_reg && point_reg.last_point |=> !point_valid_reg,
        "a point of the next curve follows the last point directly")

endmodule

// ----- src/cubic_bezier_sampler.sv -----
// ----------------------------------------------------------------------------
// cubic_bezier_sampler
// Samples one cubic Bezier curve at t = i/n for i = 1..n, one point per cycle.
// ----------------------------------------------------------------------------
// A curve is taken when start is high and busy is low. The block then emits
// n points (n is the segment count, 0 read as 1 and anything above 64 read as
// 64), one per cycle with point_valid high, the last one flagged. The first
// point passes from the sequencer through the sample register and the
// evaluation pipeline stages, and busy drops once the last point has been
// shown; the sequencer that issues one t per cycle sets the rate. Points
// cannot be held off: each is shown for exactly one cycle. Writing the
// segment count starts a serial division of 65536 by the count, during
// which busy is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cubic_bezier_sampler
    import cbs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  curve_t           curve,
    output logic             busy,
    input  logic             cfg_wr_en,
    input  logic [SEG_W-1:0] cfg_wr_data,
    output logic             point_valid,
    output point_t           point
);

    logic [SEG_W-1:0] n_reg;
    curve_t           curve_reg;
    logic             seq_active_reg;
    logic [SEG_W-1:0] idx_reg;
    logic [T_W-1:0]   t_reg;
    logic [SEG_W-1:0] racc_reg;
    sample_t          smp_reg;

    div_stat_t        div_stat;
    logic             pipe_busy;
    logic             accept;
    logic [SEG_W-1:0] seg_clamped;

    logic [SEG_W:0]   racc_sum;
    logic [SEG_W:0]   racc_diff;
    logic             carry;
    logic [SEG_W-1:0] racc_new;
    logic [T_W-1:0]   t_new;
    logic             is_last;

    assign seg_clamped = clamp_segments(cfg_wr_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_reg <= SEG_RESET;
        else if (cfg_wr_en)
            n_reg <= seg_clamped;
    end

    cbs_divider u_divider
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg_wr_en),
        .divisor (seg_clamped),
        .stat    (div_stat)
    );

    assign busy   = div_stat.busy | seq_active_reg | smp_reg.valid | pipe_busy;
    assign accept = start & ~busy;

    // t steps by the quotient of 65536 / n; the remainder accumulates and
    // adds one more whenever it reaches n, so t hits exactly 1.0 at i = n.
    assign racc_sum  = {1'b0, racc_reg} + {1'b0, div_stat.remainder};
    assign carry     = racc_sum >= {1'b0, n_reg};
    assign racc_diff = racc_sum - {1'b0, n_reg};
    assign racc_new  = carry ? racc_diff[SEG_W-1:0] : racc_sum[SEG_W-1:0];
    assign t_new     = t_reg + div_stat.quotient + {{(T_W-1){1'b0}}, carry};
    assign is_last   = idx_reg == n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_active_reg <= 1'b0;
            idx_reg        <= '0;
            t_reg          <= '0;
            racc_reg       <= '0;
            smp_reg        <= '0;
        end
        else
        begin
            smp_reg.valid <= 1'b0;
            if (accept)
            begin
                seq_active_reg <= 1'b1;
                idx_reg        <= SEG_MIN;
                t_reg          <= '0;
                racc_reg       <= '0;
            end
            else if (seq_active_reg)
            begin
                smp_reg.valid <= 1'b1;
                smp_reg.last  <= is_last;
                smp_reg.t     <= t_new;
                t_reg         <= t_new;
                racc_reg      <= racc_new;
                idx_reg       <= idx_reg + 1'b1;
                if (is_last)
                    seq_active_reg <= 1'b0;
            end
        end
    end

    // The curve word is held for the whole run; busy keeps it from changing.
    always_ff @(posedge clk)
    begin
        if (accept)
            curve_reg <= curve;
    end

    cbs_eval_pipe u_eval_pipe
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .smp         (smp_reg),
        .curve       (curve_reg),
        .point_valid (point_valid),
        .point       (point),
        .pipe_busy   (pipe_busy)
    );

    `CBS_ASSERT(a_accept_starts_run, clk, rst_n,
        accept |=> seq_active_reg && (idx_reg == SEG_MIN),
        "accepted curve did not start the sequencer")
    `CBS_ASSERT(a_samples_from_sequencer, clk, rst_n,
        !seq_active_reg |=> !smp_reg.valid,
        "sample issued with the sequencer idle")
    `CBS_ASSERT(a_last_ends_run, clk, rst_n,
        smp_reg.valid && smp_reg.last |-> !seq_active_reg,
        "sequencer still running after the last sample")
    `CBS_NEVER(a_point_while_idle, clk, rst_n,
        point_valid && !busy,
        "point shown while the block reports idle")

endmodule
